[rtl/lzwdc_pkg.sv]
// Package for the LZW dictionary compressor: code width, special codes and item types.
// Used by lzw_dictionary_compressor_core and lzwdc_checker; depends on nothing.
package lzwdc_pkg;

	// Code width and derived sizes
	localparam int CODE_BITS  = 12;
	localparam int DICT_SIZE  = 1 << CODE_BITS;
	localparam int HASH_SHIFT = CODE_BITS - 8;

	typedef logic [CODE_BITS-1:0] code_t;

	// Special codes
	localparam code_t FIRST_FREE_CODE = code_t'(256);
	localparam code_t TERM_CODE       = code_t'(DICT_SIZE - 1);

	// Hash slot markers: real codes stored in a slot are always >= 256
	localparam code_t EMPTY_SLOT = code_t'(0);
	localparam code_t TOMB_SLOT  = code_t'(1);

	// Input operations
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} sym_item_t;

	typedef struct packed {
		code_t code;
		logic  last;
	} code_item_t;

endpackage

[rtl/lzw_dictionary_compressor_core.sv]
// LZW compressor core: 12-bit code dictionary, hashed lookup with linear probing.
// The first byte of a file only loads the prefix; an empty end of file is ignored. A later
// byte probes the hash table from its hashed slot until a hit, an empty slot or all 4096
// slots probed; a live code in a slot adds a dictionary compare. One item at a time; the
// probe loop sets the rate. Results leave through one register.
// Reset (arst_n, async): clears control state, then a pass empties all 4096 hash slots.
module lzw_dictionary_compressor_core
	import lzwdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_valid,
	output logic       sym_stall,
	input  sym_item_t  sym_item,
	output logic       code_valid,
	input  logic       code_stall,
	output code_item_t code_item
);

	// Sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_TRD   = 4'd2;
	localparam logic [3:0] S_TCHK  = 4'd3;
	localparam logic [3:0] S_DCHK  = 4'd4;
	localparam logic [3:0] S_MISS  = 4'd5;
	localparam logic [3:0] S_INS   = 4'd6;
	localparam logic [3:0] S_EOF1  = 4'd7;
	localparam logic [3:0] S_EOF2  = 4'd8;
	localparam logic [3:0] S_TOMB  = 4'd9;

	logic [3:0] state_q;
	code_t      clr_q;
	code_t      prefix_q;
	logic       have_q;
	code_t      nfc_q;
	logic       wrapped_q;
	logic [7:0] byte_q;
	code_t      slot_q;
	code_t      probe_q;
	code_t      free_q;
	logic       free_found_q;
	logic       out_valid_q;
	code_item_t out_q;

	// Memories: hash table (slot -> code), dictionary (code -> pair), reverse map (code -> slot)
	code_t      tbl_mem       [DICT_SIZE];
	code_t      dict_pfx_mem  [DICT_SIZE];
	logic [7:0] dict_byte_mem [DICT_SIZE];
	code_t      slot_of_mem   [DICT_SIZE];

	code_t      tbl_rd_q;
	code_t      dpfx_rd_q;
	logic [7:0] dbyte_rd_q;
	code_t      old_slot_q;

	logic  out_free;
	logic  out_load;
	logic  last_probe;
	logic  slot_reusable;
	logic  ins_we;
	logic  tbl_we;
	code_t tbl_waddr;
	code_t tbl_wdata;
	code_t hash_slot;

	assign sym_stall  = (state_q != S_IDLE);
	assign code_valid = out_valid_q;
	assign code_item  = out_q;

	assign out_free      = !out_valid_q || !code_stall;
	assign out_load      = out_free &&
		((state_q == S_MISS) || (state_q == S_EOF1) || (state_q == S_EOF2));
	assign last_probe    = (probe_q == '1);
	assign slot_reusable = (tbl_rd_q < FIRST_FREE_CODE) || (tbl_rd_q >= nfc_q);
	assign ins_we        = (state_q == S_INS) && (nfc_q != TERM_CODE);
	assign hash_slot     = prefix_q ^ (code_t'(sym_item.data_byte) << HASH_SHIFT);

	// Hash table write port: clearing pass, tombstone of a recycled code, new entry
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = clr_q;
		tbl_wdata = EMPTY_SLOT;
		unique case (state_q)
			S_CLEAR: begin
				tbl_we = 1'b1;
			end
			S_TOMB: begin
				// old slot is dropped only while it still holds the recycled code
				if (wrapped_q && (nfc_q != TERM_CODE) && (tbl_rd_q == nfc_q)) begin
					tbl_we    = 1'b1;
					tbl_waddr = old_slot_q;
					tbl_wdata = TOMB_SLOT;
				end
			end
			S_INS: begin
				if (nfc_q != TERM_CODE) begin
					tbl_we    = 1'b1;
					tbl_waddr = free_q;
					tbl_wdata = nfc_q;
				end
			end
			default: ;
		endcase
	end

	// Hash table: probe read, or a read of the recycled code's old slot
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (state_q == S_TRD) begin
			tbl_rd_q <= tbl_mem[slot_q];
		end else if (state_q == S_MISS) begin
			tbl_rd_q <= tbl_mem[old_slot_q];
		end
	end

	// Dictionary pairs, read at the code found in the probed slot
	always_ff @(posedge clk) begin
		if (ins_we) begin
			dict_pfx_mem[nfc_q]  <= prefix_q;
			dict_byte_mem[nfc_q] <= byte_q;
		end
		if (state_q == S_TCHK) begin
			dpfx_rd_q  <= dict_pfx_mem[tbl_rd_q];
			dbyte_rd_q <= dict_byte_mem[tbl_rd_q];
		end
	end

	// Slot that holds each code; read every cycle, but used only once the codes have wrapped
	always_ff @(posedge clk) begin
		if (ins_we) begin
			slot_of_mem[nfc_q] <= free_q;
		end
		old_slot_q <= slot_of_mem[nfc_q];
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			prefix_q     <= '0;
			have_q       <= 1'b0;
			nfc_q        <= FIRST_FREE_CODE;
			wrapped_q    <= 1'b0;
			byte_q       <= '0;
			slot_q       <= '0;
			probe_q      <= '0;
			free_q       <= '0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !code_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + code_t'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (sym_valid) begin
						if (sym_item.op == OP_EOF) begin
							if (have_q) begin
								state_q <= S_EOF1;
							end
						end else if (!have_q) begin
							prefix_q <= code_t'(sym_item.data_byte);
							have_q   <= 1'b1;
						end else begin
							byte_q       <= sym_item.data_byte;
							slot_q       <= hash_slot;
							probe_q      <= '0;
							free_found_q <= 1'b0;
							state_q      <= S_TRD;
						end
					end
				end
				S_TRD: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (tbl_rd_q == EMPTY_SLOT) begin
						// end of the probe chain: pair absent
						if (!free_found_q) begin
							free_q <= slot_q;
						end
						state_q <= S_MISS;
					end else if (slot_reusable) begin
						// tombstone or code outside the live range
						if (!free_found_q) begin
							free_q       <= slot_q;
							free_found_q <= 1'b1;
						end
						if (last_probe) begin
							state_q <= S_MISS;
						end else begin
							slot_q  <= slot_q + code_t'(1);
							probe_q <= probe_q + code_t'(1);
							state_q <= S_TRD;
						end
					end else begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if ((dpfx_rd_q == prefix_q) && (dbyte_rd_q == byte_q)) begin
						prefix_q <= tbl_rd_q;
						state_q  <= S_IDLE;
					end else if (last_probe) begin
						state_q <= S_MISS;
					end else begin
						slot_q  <= slot_q + code_t'(1);
						probe_q <= probe_q + code_t'(1);
						state_q <= S_TRD;
					end
				end
				S_MISS: begin
					if (out_free) begin
						out_q.code <= prefix_q;
						out_q.last <= 1'b1;
						state_q    <= S_TOMB;
					end
				end
				S_TOMB: begin
					state_q <= S_INS;
				end
				S_INS: begin
					if (nfc_q == TERM_CODE) begin
						nfc_q     <= FIRST_FREE_CODE;
						wrapped_q <= 1'b1;
					end else begin
						nfc_q <= nfc_q + code_t'(1);
					end
					prefix_q <= code_t'(byte_q);
					state_q  <= S_IDLE;
				end
				S_EOF1: begin
					if (out_free) begin
						out_q.code <= prefix_q;
						out_q.last <= 1'b0;
						state_q    <= S_EOF2;
					end
				end
				S_EOF2: begin
					if (out_free) begin
						out_q.code <= TERM_CODE;
						out_q.last <= 1'b1;
						have_q     <= 1'b0;
						prefix_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/lzwdc_checker.sv]
// Port-level checks for the LZW compressor core, bound to lzw_dictionary_compressor_core.
// Depends on lzwdc_pkg for the item types and the terminator code.
module lzwdc_checker
	import lzwdc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       sym_stall,
	input logic       code_valid,
	input logic       code_stall,
	input code_item_t code_item
);

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code_item))
		else $error("result item changed while stalled");

	// The terminator code only ever closes an item's results
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && (code_item.code == TERM_CODE) |-> code_item.last)
		else $error("terminator code without last");

	// The end-of-file prefix is followed right away by the terminator
	a_term_follows: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_stall && !code_item.last |=>
			code_valid && (code_item.code == TERM_CODE) && code_item.last)
		else $error("terminator missing after end-of-file prefix");

	// No new item is taken while the terminator is still pending
	a_busy_eof: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_item.last |-> sym_stall)
		else $error("input accepted during end-of-file output");

endmodule

bind lzw_dictionary_compressor_core lzwdc_checker u_lzwdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.sym_stall  (sym_stall),
	.code_valid (code_valid),
	.code_stall (code_stall),
	.code_item  (code_item)
);
